// ----- rtl/cpet_pkg.sv -----
// shared constants, types and the table hash for the collision pair event tracker
package cpet_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ID_BITS     = 16;
	localparam int COORD_BITS  = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam int TABLE_ABITS = $clog2(TABLE_DEPTH);
	localparam int KEY_BITS    = 2 * ID_BITS;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_ENTER = 2'd1;
	localparam logic [1:0] EV_STAY  = 2'd2;
	localparam logic [1:0] EV_EXIT  = 2'd3;

	typedef struct packed {
		logic                clear_all;
		logic [KEY_BITS-1:0] key;
		logic                hit;
	} item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic                touch;
	} entry_t;

	// xor fold of the pair key down to a table address
	function automatic logic [TABLE_ABITS-1:0] key_hash(input logic [KEY_BITS-1:0] key);
		logic [TABLE_ABITS-1:0] h;
		h = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			h[i % TABLE_ABITS] = h[i % TABLE_ABITS] ^ key[i];
		end
		return h;
	endfunction

endpackage

// ----- rtl/cpet_if.sv -----
// channel interfaces for pair items and event results
interface cpet_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  clear_all;
	logic        [cpet_pkg::ID_BITS-1:0]    first_id;
	logic        [cpet_pkg::ID_BITS-1:0]    second_id;
	logic signed [cpet_pkg::COORD_BITS-1:0] first_cx;
	logic signed [cpet_pkg::COORD_BITS-1:0] first_cy;
	logic signed [cpet_pkg::COORD_BITS-1:0] first_w;
	logic signed [cpet_pkg::COORD_BITS-1:0] first_h;
	logic signed [cpet_pkg::COORD_BITS-1:0] second_cx;
	logic signed [cpet_pkg::COORD_BITS-1:0] second_cy;
	logic signed [cpet_pkg::COORD_BITS-1:0] second_w;
	logic signed [cpet_pkg::COORD_BITS-1:0] second_h;

	modport source (
		output valid, clear_all, first_id, second_id, first_cx, first_cy, first_w, first_h,
		       second_cx, second_cy, second_w, second_h,
		input  ready
	);
	modport sink (
		input  valid, clear_all, first_id, second_id, first_cx, first_cy, first_w, first_h,
		       second_cx, second_cy, second_w, second_h,
		output ready
	);
endinterface

interface cpet_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic       overlapping;
	logic       table_full;

	modport source (output valid, event_res, overlapping, table_full, input ready);
	modport sink (input valid, event_res, overlapping, table_full, output ready);
endinterface

// ----- rtl/cpet_front.sv -----
// front end: takes pair items, runs the box overlap test, forms the pair key
module cpet_front (
	input  logic              clk,
	input  logic              arst_n,
	cpet_in_if.sink           pairs,
	output logic              push_valid,
	output cpet_pkg::item_t   push_data,
	input  logic              push_ready
);

	logic                                  adv;
	logic                                  v_s1, v_s2;
	logic                                  clr_s1, clr_s2;
	logic [cpet_pkg::KEY_BITS-1:0]         key_s1, key_s2;
	logic signed [cpet_pkg::DIFF_BITS-1:0] dx_s1, dy_s1, sx_s1, sy_s1;
	logic [cpet_pkg::DIFF_BITS-1:0]        adx_s2, ady_s2, asx_s2, asy_s2;
	logic                                  hit_x, hit_y;

	assign adv         = !v_s2 || push_ready;
	assign pairs.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pairs.valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: center differences and size sums, sign extended by one bit
	always_ff @(posedge clk) begin
		if (adv) begin
			clr_s1 <= pairs.clear_all;
			key_s1 <= {pairs.first_id, pairs.second_id};
			dx_s1  <= cpet_pkg::DIFF_BITS'(pairs.first_cx) - cpet_pkg::DIFF_BITS'(pairs.second_cx);
			dy_s1  <= cpet_pkg::DIFF_BITS'(pairs.first_cy) - cpet_pkg::DIFF_BITS'(pairs.second_cy);
			sx_s1  <= cpet_pkg::DIFF_BITS'(pairs.first_w) + cpet_pkg::DIFF_BITS'(pairs.second_w);
			sy_s1  <= cpet_pkg::DIFF_BITS'(pairs.first_h) + cpet_pkg::DIFF_BITS'(pairs.second_h);
		end
	end

	// stage 2: magnitudes, the most negative value maps to its unsigned magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			clr_s2 <= clr_s1;
			key_s2 <= key_s1;
			adx_s2 <= dx_s1[cpet_pkg::DIFF_BITS-1] ? -dx_s1 : dx_s1;
			ady_s2 <= dy_s1[cpet_pkg::DIFF_BITS-1] ? -dy_s1 : dy_s1;
			asx_s2 <= sx_s1[cpet_pkg::DIFF_BITS-1] ? -sx_s1 : sx_s1;
			asy_s2 <= sy_s1[cpet_pkg::DIFF_BITS-1] ? -sy_s1 : sy_s1;
		end
	end

	assign hit_x = {adx_s2, 1'b0} <= {1'b0, asx_s2};
	assign hit_y = {ady_s2, 1'b0} <= {1'b0, asy_s2};

	assign push_valid          = v_s2;
	assign push_data.clear_all = clr_s2;
	assign push_data.key       = key_s2;
	assign push_data.hit       = hit_x && hit_y;

endmodule

// ----- rtl/cpet_queue.sv -----
// small first-in first-out queue between the front and back ends
module cpet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  cpet_pkg::item_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output cpet_pkg::item_t pop_data,
	input  logic            pop_ready
);

	cpet_pkg::item_t                q_mem [cpet_pkg::QUEUE_DEPTH];
	logic [cpet_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [cpet_pkg::QPTR_BITS:0]   count_q;
	logic                           do_push, do_pop;

	assign push_ready = count_q != (cpet_pkg::QPTR_BITS + 1)'(cpet_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = q_mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_mem[wr_ptr_q] <= push_data;
	end

endmodule

// ----- rtl/cpet_back.sv -----
// back end: hashed pair table with linear probing, event decision, result register
module cpet_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  cpet_pkg::item_t item,
	output logic            item_pop,
	cpet_out_if.source      events
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;

	logic [1:0]                       state_q, state_d;
	logic [cpet_pkg::TABLE_ABITS-1:0] probe_q, probe_d;
	logic [cpet_pkg::TABLE_ABITS-1:0] cnt_q, cnt_d;
	logic [cpet_pkg::TABLE_DEPTH-1:0] valid_q;
	cpet_pkg::entry_t                 mem [cpet_pkg::TABLE_DEPTH];
	cpet_pkg::entry_t                 rd_q;
	cpet_pkg::entry_t                 wr_data;
	logic                             wr_en, set_valid, clr_all;
	logic                             emit, can_emit;
	logic [1:0]                       ev;
	logic                             ovl, full;
	logic                             out_valid_q;
	logic [1:0]                       event_res_q;
	logic                             overlapping_q, table_full_q;

	assign can_emit = !out_valid_q || events.ready;

	always_comb begin
		state_d   = state_q;
		probe_d   = probe_q;
		cnt_d     = cnt_q;
		item_pop  = 1'b0;
		emit      = 1'b0;
		ev        = cpet_pkg::EV_NONE;
		ovl       = 1'b0;
		full      = 1'b0;
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_all   = 1'b0;
		wr_data   = '{key: item.key, touch: item.hit};
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.clear_all) begin
						if (can_emit) begin
							clr_all  = 1'b1;
							emit     = 1'b1;
							item_pop = 1'b1;
						end
					end else begin
						probe_d = cpet_pkg::key_hash(item.key);
						cnt_d   = '0;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (!valid_q[probe_q]) begin
					// free slot: the pair is new, store it with the current touch state
					if (can_emit) begin
						wr_en     = 1'b1;
						set_valid = 1'b1;
						emit      = 1'b1;
						item_pop  = 1'b1;
						ovl       = item.hit;
						ev        = item.hit ? cpet_pkg::EV_ENTER : cpet_pkg::EV_NONE;
						state_d   = ST_IDLE;
					end
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (rd_q.key == item.key) begin
					if (can_emit) begin
						wr_en    = 1'b1;
						emit     = 1'b1;
						item_pop = 1'b1;
						ovl      = item.hit;
						if (item.hit) begin
							ev = rd_q.touch ? cpet_pkg::EV_STAY : cpet_pkg::EV_ENTER;
						end else begin
							ev = rd_q.touch ? cpet_pkg::EV_EXIT : cpet_pkg::EV_NONE;
						end
						state_d = ST_IDLE;
					end
				end else if (cnt_q == cpet_pkg::TABLE_ABITS'(cpet_pkg::TABLE_DEPTH - 1)) begin
					// every slot probed and taken by other pairs
					if (can_emit) begin
						emit     = 1'b1;
						item_pop = 1'b1;
						full     = 1'b1;
						ovl      = item.hit;
						ev       = item.hit ? cpet_pkg::EV_ENTER : cpet_pkg::EV_NONE;
						state_d  = ST_IDLE;
					end
				end else begin
					probe_d = probe_q + 1'b1;
					cnt_d   = cnt_q + 1'b1;
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			probe_q     <= '0;
			cnt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			probe_q <= probe_d;
			cnt_q   <= cnt_d;
			if (clr_all) begin
				valid_q <= '0;
			end else if (set_valid) begin
				valid_q[probe_q] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[probe_q];
		if (wr_en) mem[probe_q] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			event_res_q   <= ev;
			overlapping_q <= ovl;
			table_full_q  <= full;
		end
	end

	assign events.valid       = out_valid_q;
	assign events.event_res   = event_res_q;
	assign events.overlapping = overlapping_q;
	assign events.table_full  = table_full_q;

endmodule

// ----- rtl/collision_pair_event_tracker_top.sv -----
// collision pair event tracker top level
// Items arrive on the pairs channel (valid/ready): an ordered pair of collider
// handles with both box centers and sizes, or a clear request. Each item gives
// exactly one transaction on the events channel: none, enter, stay or exit, the
// current overlap flag and a table-full flag for a new pair that could not be
// stored. The front end runs the overlap test in two register stages and hands
// items through a two-entry queue to the back end, which looks the pair up in a
// 256-entry hashed table with linear probing, one memory read per probe.
// A clear is reported straight from the back end's idle state; a pair is hashed,
// then each probe reads a slot and, if it is taken, compares its key before
// moving on to the next slot (at most 256 probes). The back end handles one
// item at a time, so a steady stream is bound by the table probe loop.
// Reset empties the pair table at once; no sweep is needed. When the receiver
// stalls, the result register holds, the back end finishes its current item up
// to the point of reporting, the queue and front stages fill, and ready drops.
module collision_pair_event_tracker_top (
	input  logic       clk,
	input  logic       arst_n,
	cpet_in_if.sink    pairs,
	cpet_out_if.source events
);

	logic            q_push_valid, q_push_ready;
	logic            q_pop_valid, q_pop_ready;
	cpet_pkg::item_t q_push_data, q_pop_data;

	cpet_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pairs      (pairs),
		.push_valid (q_push_valid),
		.push_data  (q_push_data),
		.push_ready (q_push_ready)
	);

	cpet_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_data  (q_push_data),
		.push_ready (q_push_ready),
		.pop_valid  (q_pop_valid),
		.pop_data   (q_pop_data),
		.pop_ready  (q_pop_ready)
	);

	cpet_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_pop_valid),
		.item       (q_pop_data),
		.item_pop   (q_pop_ready),
		.events     (events)
	);

	// a full table only ever reports a pair as new
	a_full_new_only: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.table_full |->
			(events.event_res == cpet_pkg::EV_NONE || events.event_res == cpet_pkg::EV_ENTER))
		else $error("table full with a stay or exit event");

	// overlap flag agrees with the event code
	a_overlap_event: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> (events.overlapping ==
			(events.event_res == cpet_pkg::EV_ENTER || events.event_res == cpet_pkg::EV_STAY)))
		else $error("overlap flag and event code disagree");

	// a queue head is only taken once the back end can report it
	a_pop_reports: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop_valid && q_pop_ready |=> events.valid)
		else $error("item left the queue without a result");

	// the front end holds its item while the queue is full
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
		else $error("front end dropped an item against a full queue");

endmodule

// ----- verif/cpet_event_checker.sv -----
`timescale 1ns / 100ps
// event checker: tracks the pair table and compares each event transaction
module cpet_event_checker
	import cpet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cpet_in_if          pairs,
	cpet_out_if         events,
	output int unsigned pending_events,
	output int unsigned mismatch_count
);

	typedef struct packed {
		logic [1:0] event_res;
		logic       overlapping;
		logic       table_full;
	} pair_event_t;

	pair_event_t event_expect_q[$];

	// touching flag per stored pair, keyed by {first_id, second_id}
	logic pair_touch [logic [KEY_BITS-1:0]];

	// 2*|c1-c2| <= |s1+s2|, done wide enough that nothing wraps
	function automatic logic axis_meets(input logic signed [COORD_BITS-1:0] c1, c2, s1, s2);
		longint gap;
		longint span;
		gap  = longint'(c1) - longint'(c2);
		span = longint'(s1) + longint'(s2);
		if (gap < 0) gap = -gap;
		if (span < 0) span = -span;
		return (2 * gap) <= span;
	endfunction

	function automatic pair_event_t track_pair();
		pair_event_t          res;
		logic [KEY_BITS-1:0]  key;
		logic                 was_touching;
		logic                 hit;
		res = '0;
		if (pairs.clear_all) begin
			pair_touch.delete();
			res.event_res = EV_NONE;
			return res;
		end
		key = {pairs.first_id, pairs.second_id};
		hit = axis_meets(pairs.first_cx, pairs.second_cx, pairs.first_w, pairs.second_w) &&
		      axis_meets(pairs.first_cy, pairs.second_cy, pairs.first_h, pairs.second_h);
		was_touching = 1'b0;
		if (pair_touch.exists(key)) begin
			was_touching = pair_touch[key];
			pair_touch[key] = hit;
		end else if (pair_touch.num() < TABLE_DEPTH) begin
			pair_touch[key] = hit;
		end else begin
			// no room: reported as a new pair, nothing remembered
			res.table_full = 1'b1;
		end
		if (hit) res.event_res = was_touching ? EV_STAY : EV_ENTER;
		else     res.event_res = was_touching ? EV_EXIT : EV_NONE;
		res.overlapping = hit;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_event_t want;
		int unsigned faults;
		if (!arst_n) begin
			event_expect_q.delete();
			pair_touch.delete();
			pending_events <= 0;
			mismatch_count <= 0;
		end else begin
			faults = 0;
			if (events.valid && events.ready) begin
				if (event_expect_q.size() == 0) begin
					$error("event transaction with no pair transaction waiting");
					faults++;
				end else begin
					want = event_expect_q.pop_front();
					if (events.event_res !== want.event_res) begin
						$error("event_res: expected %0d, actual %0d", want.event_res,
						       events.event_res);
						faults++;
					end
					if (events.overlapping !== want.overlapping) begin
						$error("overlapping: expected %0d, actual %0d", want.overlapping,
						       events.overlapping);
						faults++;
					end
					if (events.table_full !== want.table_full) begin
						$error("table_full: expected %0d, actual %0d", want.table_full,
						       events.table_full);
						faults++;
					end
				end
			end
			if (pairs.valid && pairs.ready) event_expect_q.push_back(track_pair());
			pending_events <= event_expect_q.size();
			mismatch_count <= mismatch_count + faults;
		end
	end

endmodule

// ----- verif/collision_pair_event_tracker_top_tb.sv -----
`timescale 1ns / 100ps
// stimulus and verdict for the collision pair event tracker
module collision_pair_event_tracker_top_tb;
	import cpet_pkg::*;

	localparam int          POOL_SIZE   = 12;
	localparam int          SIZE_SPREAD = 4096;
	localparam int          DRAIN_WAIT  = 600;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int          COORD_MAX   = 8388607;
	localparam int          COORD_MIN   = -8388608;

	typedef struct {
		logic                         clear_all;
		logic [ID_BITS-1:0]           a_id;
		logic [ID_BITS-1:0]           b_id;
		logic signed [COORD_BITS-1:0] a_cx, a_cy, a_w, a_h;
		logic signed [COORD_BITS-1:0] b_cx, b_cy, b_w, b_h;
	} pair_msg_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        sink_ready = 1'b0;
	logic        quiet_tail = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned pending_events;
	int unsigned mismatch_count;

	logic [ID_BITS-1:0] pool_a [POOL_SIZE];
	logic [ID_BITS-1:0] pool_b [POOL_SIZE];
	logic [ID_BITS-1:0] fill_b [TABLE_DEPTH];

	cpet_in_if  pairs_ch ();
	cpet_out_if events_ch ();

	assign events_ch.ready = sink_ready;

	collision_pair_event_tracker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs_ch),
		.events (events_ch)
	);

	cpet_event_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.pairs          (pairs_ch),
		.events         (events_ch),
		.pending_events (pending_events),
		.mismatch_count (mismatch_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stalls at random in short bursts, with no new bursts once the quiet tail starts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			sink_ready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	function automatic pair_msg_t mk(input logic clear, input int a, b, acx, acy, aw, ah,
	                                 input int bcx, bcy, bw, bh);
		pair_msg_t m;
		m.clear_all = clear;
		m.a_id = ID_BITS'(a);
		m.b_id = ID_BITS'(b);
		m.a_cx = COORD_BITS'(acx);
		m.a_cy = COORD_BITS'(acy);
		m.a_w  = COORD_BITS'(aw);
		m.a_h  = COORD_BITS'(ah);
		m.b_cx = COORD_BITS'(bcx);
		m.b_cy = COORD_BITS'(bcy);
		m.b_w  = COORD_BITS'(bw);
		m.b_h  = COORD_BITS'(bh);
		return m;
	endfunction

	function automatic pair_msg_t wide();
		return mk(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
		          $urandom, $urandom, $urandom, $urandom);
	endfunction

	// one axis placed to meet or miss, sometimes right on the boundary
	function automatic void place_axis(input logic meet,
	                                   output logic signed [COORD_BITS-1:0] c1, c2, s1, s2);
		int w1, w2, span, gap, base;
		w1 = int'($urandom_range(0, 2 * SIZE_SPREAD)) - SIZE_SPREAD;
		w2 = int'($urandom_range(0, 2 * SIZE_SPREAD)) - SIZE_SPREAD;
		span = w1 + w2;
		if (span < 0) span = -span;
		if ($urandom_range(0, 7) == 0) gap = meet ? span / 2 : span / 2 + 1;
		else if (meet) gap = int'($urandom_range(0, span / 2));
		else gap = span / 2 + 1 + int'($urandom_range(0, SIZE_SPREAD));
		if ($urandom_range(0, 1)) gap = -gap;
		base = int'($urandom_range(0, 1 << 23)) - (1 << 22);
		c1 = COORD_BITS'(base + gap);
		c2 = COORD_BITS'(base);
		s1 = COORD_BITS'(w1);
		s2 = COORD_BITS'(w2);
	endfunction

	function automatic pair_msg_t placed(input logic [ID_BITS-1:0] a, b, input logic meet);
		pair_msg_t m;
		int miss_sel;
		m.clear_all = 1'b0;
		m.a_id = a;
		m.b_id = b;
		// 0: x misses, 1: y misses, 2: both miss, 3: both meet
		miss_sel = meet ? 3 : int'($urandom_range(0, 2));
		place_axis(miss_sel == 1 || miss_sel == 3, m.a_cx, m.b_cx, m.a_w, m.b_w);
		place_axis(miss_sel == 0 || miss_sel == 3, m.a_cy, m.b_cy, m.a_h, m.b_h);
		return m;
	endfunction

	function automatic pair_msg_t roam_item();
		pair_msg_t m;
		int r, p;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, POOL_SIZE - 1);
		if (r < 3) begin
			m = wide();
			m.clear_all = 1'b1;
		end else if (r < 13) begin
			m = wide();
		end else if (r < 22) begin
			m = wide();
			m.a_id = pool_a[p];
			m.b_id = pool_b[p];
		end else begin
			m = placed(pool_a[p], pool_b[p], 1'($urandom_range(0, 1)));
		end
		return m;
	endfunction

	task automatic send_pair(input pair_msg_t m);
		pairs_ch.valid     <= 1'b1;
		pairs_ch.clear_all <= m.clear_all;
		pairs_ch.first_id  <= m.a_id;
		pairs_ch.second_id <= m.b_id;
		pairs_ch.first_cx  <= m.a_cx;
		pairs_ch.first_cy  <= m.a_cy;
		pairs_ch.first_w   <= m.a_w;
		pairs_ch.first_h   <= m.a_h;
		pairs_ch.second_cx <= m.b_cx;
		pairs_ch.second_cy <= m.b_cy;
		pairs_ch.second_w  <= m.b_w;
		pairs_ch.second_h  <= m.b_h;
		@(posedge clk);
		while (!pairs_ch.ready) @(posedge clk);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			pairs_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	initial begin
		pair_msg_t m;
		arst_n             <= 1'b0;
		pairs_ch.valid     <= 1'b0;
		pairs_ch.clear_all <= 1'b0;
		pairs_ch.first_id  <= '0;
		pairs_ch.second_id <= '0;
		pairs_ch.first_cx  <= '0;
		pairs_ch.first_cy  <= '0;
		pairs_ch.first_w   <= '0;
		pairs_ch.first_h   <= '0;
		pairs_ch.second_cx <= '0;
		pairs_ch.second_cy <= '0;
		pairs_ch.second_w  <= '0;
		pairs_ch.second_h  <= '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_a[i] = ID_BITS'($urandom);
			pool_b[i] = ID_BITS'($urandom);
		end
		// the same handles in swapped order form a different pair
		pool_a[1] = pool_b[0];
		pool_b[1] = pool_a[0];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every event, boundaries, extremes, negative sizes, clears
		m = wide();
		m.clear_all = 1'b1;
		send_pair(m);
		send_pair(placed(16'h0000, 16'h0000, 1'b1));
		send_pair(placed(16'h0000, 16'h0000, 1'b1));
		send_pair(placed(16'h0000, 16'h0000, 1'b0));
		send_pair(placed(16'h0000, 16'h0000, 1'b0));
		send_pair(placed(16'h0000, 16'h0000, 1'b1));
		send_pair(mk(1'b0, 16'hffff, 16'hffff, COORD_MAX, 0, COORD_MIN, 0,
		             COORD_MIN, 0, COORD_MIN, 0));
		send_pair(mk(1'b0, 16'hffff, 16'hffff, 0, 0, COORD_MAX, COORD_MAX,
		             0, 0, COORD_MAX, COORD_MAX));
		send_pair(placed(16'h0001, 16'h0002, 1'b1));
		send_pair(placed(16'h0002, 16'h0001, 1'b0));
		send_pair(placed(16'h0001, 16'h0002, 1'b0));
		// just touching, then one step past it
		send_pair(mk(1'b0, 3, 4, 100, 0, 150, 0, 0, 0, 50, 0));
		send_pair(mk(1'b0, 3, 4, 101, 0, 150, 0, 0, 0, 50, 0));
		send_pair(mk(1'b0, 5, 6, 100, 7, -150, -10, 0, 7, -50, 10));
		send_pair(mk(1'b0, 5, 6, 0, 7, 300, -10, 100, 7, -100, 10));
		m = wide();
		m.clear_all = 1'b1;
		send_pair(m);
		send_pair(placed(16'h0000, 16'h0000, 1'b1));
		send_pair(placed(16'h0001, 16'h0002, 1'b0));

		repeat (330) send_pair(roam_item());

		// fill the table to the brim, then hit it with known and new pairs
		m = wide();
		m.clear_all = 1'b1;
		send_pair(m);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			fill_b[i] = ID_BITS'($urandom);
			send_pair(placed(ID_BITS'(i), fill_b[i], 1'($urandom_range(0, 1))));
		end
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 1)) begin
				int k;
				k = $urandom_range(0, TABLE_DEPTH - 1);
				send_pair(placed(ID_BITS'(k), fill_b[k], 1'($urandom_range(0, 1))));
			end else begin
				send_pair(placed(ID_BITS'(TABLE_DEPTH + i), ID_BITS'($urandom),
				                 1'($urandom_range(0, 1))));
			end
		end
		m = wide();
		m.clear_all = 1'b1;
		send_pair(m);

		for (int i = 0; i < 270; i++) begin
			if (i == 120) quiet_tail = 1'b1;
			send_pair(roam_item());
		end
		pairs_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending_events != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cpet_pkg.sv
rtl/cpet_if.sv
rtl/cpet_front.sv
rtl/cpet_queue.sv
rtl/cpet_back.sv
rtl/collision_pair_event_tracker_top.sv
verif/cpet_event_checker.sv
verif/collision_pair_event_tracker_top_tb.sv
